FILE: src/llcp_pkg.sv
`default_nettype none
package llcp_pkg;

    localparam int C_XW   = 32;
    localparam int C_DOTW = 51;
    localparam int C_DENW = 104;
    localparam int C_NUMW = 120;
    localparam int C_QW   = 32;
    localparam int C_DIFW = 50;
    localparam int C_DISTW = 48;
    localparam logic [C_XW-1:0] C_THR_RESET = 32'd16;

    typedef enum logic [1:0] {
        ST_GENERAL  = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_ZERO_DIR = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [C_XW-1:0] line_a_origin_x;
        logic signed [C_XW-1:0] line_a_origin_y;
        logic signed [C_XW-1:0] line_a_origin_z;
        logic signed [C_XW-1:0] line_a_dir_x;
        logic signed [C_XW-1:0] line_a_dir_y;
        logic signed [C_XW-1:0] line_a_dir_z;
        logic signed [C_XW-1:0] line_b_origin_x;
        logic signed [C_XW-1:0] line_b_origin_y;
        logic signed [C_XW-1:0] line_b_origin_z;
        logic signed [C_XW-1:0] line_b_dir_x;
        logic signed [C_XW-1:0] line_b_dir_y;
        logic signed [C_XW-1:0] line_b_dir_z;
    } t_in;

    typedef struct packed {
        logic        [C_DISTW-1:0] dist_sq;
        logic signed [C_XW-1:0]    param_s;
        logic signed [C_XW-1:0]    param_t;
        logic signed [C_XW-1:0]    near_a_x;
        logic signed [C_XW-1:0]    near_a_y;
        logic signed [C_XW-1:0]    near_a_z;
        logic signed [C_XW-1:0]    near_b_x;
        logic signed [C_XW-1:0]    near_b_y;
        logic signed [C_XW-1:0]    near_b_z;
        t_status                   status;
    } t_out;

    typedef logic [2:0][C_XW-1:0] t_vec3;

    typedef struct packed {
        t_vec3 oa;
        t_vec3 da;
        t_vec3 ob;
        t_vec3 db;
    } t_geo;

endpackage
`default_nettype wire

FILE: src/llcp_wmul.sv
`default_nettype none
module llcp_wmul import llcp_pkg::*; #(
    parameter int W = C_DOTW
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [W-1:0]   i_x,
    input  wire logic signed [W-1:0]   i_y,
    output logic signed [2*W-1:0]      o_p
);

    localparam int L  = W / 2;
    localparam int H  = W - L;
    localparam int PW = 2 * W;

    logic signed [2*H-1:0] r_hh, n_hh;
    logic signed [H+L:0]   r_hl, n_hl, r_lh, n_lh;
    logic [2*L-1:0]        r_ll, n_ll;
    logic [PW-1:0]         r_p, n_p;

    // split partial products
    always_comb begin
        n_hh = $signed(i_x[W-1:L]) * $signed(i_y[W-1:L]);
        n_hl = $signed(i_x[W-1:L]) * $signed({1'b0, i_y[L-1:0]});
        n_lh = $signed({1'b0, i_x[L-1:0]}) * $signed(i_y[W-1:L]);
        n_ll = i_x[L-1:0] * i_y[L-1:0];
    end

    always_comb begin
        n_p = (PW'(r_hh) << (2 * L)) + (PW'(r_hl) << L) + (PW'(r_lh) << L) + PW'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
            r_p  <= n_p;
        end
    end

    assign o_p = $signed(r_p);

endmodule
`default_nettype wire

FILE: src/llcp_div.sv
`default_nettype none
module llcp_div import llcp_pkg::*; #(
    parameter int NW = C_NUMW,
    parameter int DW = C_DENW,
    parameter int QW = C_QW
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic signed [DW-1:0] i_den,
    output logic signed [QW-1:0]      o_quo
);

    localparam int RW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_a_neg, n_a_neg, r_a_zero, n_a_zero;
    logic [NW-1:0] r_a_n, n_a_n;
    logic [DW-1:0] r_a_d, n_a_d;

    logic [RW-1:0] r_rem  [QW];
    logic [DW-1:0] r_d    [QW];
    logic          r_neg  [QW+1];
    logic          r_zero [QW+1];
    logic          r_ovf  [QW+1];
    logic [QW-1:0] r_q    [QW+1];

    logic [QW-1:0] lim, mag, r_out, n_out;

    // magnitudes and sign
    always_comb begin
        n_a_neg  = i_num[NW-1] ^ i_den[DW-1];
        n_a_n    = i_num[NW-1] ? (~i_num + NW'(1)) : i_num;
        n_a_d    = i_den[DW-1] ? (~i_den + DW'(1)) : i_den;
        n_a_zero = (i_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg  <= n_a_neg;
            r_a_n    <= n_a_n;
            r_a_d    <= n_a_d;
            r_a_zero <= n_a_zero;
        end
    end

    // quotient beyond the low QW bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'(r_a_n);
            r_d[0]    <= r_a_d;
            r_neg[0]  <= r_a_neg;
            r_zero[0] <= r_a_zero;
            r_ovf[0]  <= (RW'(r_a_n) >= (RW'(r_a_d) << QW));
            r_q[0]    <= '0;
        end
    end

    for (genvar gk = 0; gk < QW; gk++) begin : g_step
        localparam int SH = QW - 1 - gk;
        logic [RW-1:0] trial, diff;
        logic          ge;

        always_comb begin
            trial = RW'(r_d[gk]) << SH;
            ge    = (r_rem[gk] >= trial);
            diff  = r_rem[gk] - trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[gk+1]    <= {r_q[gk][QW-2:0], ge};
                r_neg[gk+1]  <= r_neg[gk];
                r_zero[gk+1] <= r_zero[gk];
                r_ovf[gk+1]  <= r_ovf[gk];
            end
        end

        if (gk < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gk+1] <= ge ? diff : r_rem[gk];
                    r_d[gk+1]   <= r_d[gk];
                end
            end
        end
    end

    // saturate and apply sign
    always_comb begin
        lim   = {r_neg[QW], {(QW-1){~r_neg[QW]}}};
        mag   = (r_ovf[QW] || (r_q[QW] > lim)) ? lim : r_q[QW];
        n_out = r_zero[QW] ? '0 : (r_neg[QW] ? (~mag + QW'(1)) : mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_quo = $signed(r_out);

endmodule
`default_nettype wire

FILE: src/line_line_closest_points_unit.sv
// channel   | valid    | ready     | payload     | beat
// ----------+----------+-----------+-------------+--------------------
// input     | i_valid  | o_ready   | i_data      | one line pair
// output    | o_valid  | i_ready   | o_data      | one closest-point result
// config    | i_cfg_we | -         | i_cfg_data  | parallel threshold
//
// a new beat can enter every cycle while the pipeline is not held; s and t
// are formed by two bit-per-stage dividers
// synchronous active-low reset clears the valid bits and sets the threshold to THR_RESET, 16 by default
// the whole pipeline holds when the output register is full and i_ready is low
`default_nettype none
module line_line_closest_points_unit import llcp_pkg::*; #(
    parameter logic [C_XW-1:0] THR_RESET = C_THR_RESET
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire t_in             i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output t_out                 o_data,
    input  wire logic            i_cfg_we,
    input  wire logic [C_XW-1:0] i_cfg_data
);

    localparam int DIV_LAT = C_QW + 3;
    localparam int NSTG    = 14 + DIV_LAT;
    localparam int GEO_LEN = 9 + DIV_LAT;
    localparam int MW      = 2 * (C_XW + 1);
    localparam int PRW     = 2 * C_DOTW;
    localparam int PTW     = C_XW + 17;
    localparam int SQW     = 2 * C_DIFW;
    localparam int SUMW    = SQW + 2;

    function automatic logic [C_XW-1:0] f_sat32(input logic signed [PTW-1:0] v);
        logic [C_XW-1:0] res;
        if (v[PTW-1:C_XW-1] == '0 || v[PTW-1:C_XW-1] == '1) begin
            res = v[C_XW-1:0];
        end else begin
            res = {v[PTW-1], {(C_XW-1){~v[PTW-1]}}};
        end
        return res;
    endfunction

    logic              adv;
    logic [NSTG-1:0]   r_vld, n_vld;
    logic [C_XW-1:0]   r_thr;

    t_geo              n_geo_in;
    t_geo              r_geo [GEO_LEN];

    logic signed [C_XW:0]       r_w0 [3], n_w0 [3];
    logic signed [MW-1:0]       r_p [5][3], n_p [5][3];
    logic signed [C_DOTW-1:0]   r_dot [5], n_dot [5];
    logic signed [C_DOTW-1:0]   mx [6], my [6];
    logic signed [PRW-1:0]      pr [6];
    logic signed [C_DOTW-1:0]   r_cc [3], r_ee [3];
    logic signed [C_DENW-1:0]   r_den, n_den, r_ns, n_ns, r_nt, n_nt;
    logic [C_DENW-1:0]          absden;
    t_status                    r_st8, n_st8;
    logic signed [C_NUMW-1:0]   r_nums, n_nums, r_numt, n_numt;
    logic signed [C_DENW-1:0]   r_dens, n_dens, r_dent, n_dent;
    logic signed [C_XW-1:0]     s_quo, t_quo;
    t_status                    r_st [DIV_LAT];

    logic signed [C_XW-1:0]     n_s, n_t;
    logic signed [2*C_XW-1:0]   r_ma [3], n_ma [3], r_mb [3], n_mb [3];
    t_out                       r_o44, n_o44, r_o45, r_o46, n_o46, r_o47, r_o48;
    logic signed [PTW-1:0]      r_pa [3], n_pa [3], r_pb [3], n_pb [3];
    logic signed [C_DIFW-1:0]   r_df [3], n_df [3];
    logic signed [SQW-1:0]      sq [3];
    logic [SUMW-1:0]            n_sum;
    t_out                       r_out, n_out;

    assign adv     = !r_vld[NSTG-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_out;
    assign n_vld   = {r_vld[NSTG-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_comb begin
        n_geo_in.oa = {i_data.line_a_origin_z, i_data.line_a_origin_y, i_data.line_a_origin_x};
        n_geo_in.da = {i_data.line_a_dir_z, i_data.line_a_dir_y, i_data.line_a_dir_x};
        n_geo_in.ob = {i_data.line_b_origin_z, i_data.line_b_origin_y, i_data.line_b_origin_x};
        n_geo_in.db = {i_data.line_b_dir_z, i_data.line_b_dir_y, i_data.line_b_dir_x};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_geo[0] <= n_geo_in;
            for (int k = 1; k < GEO_LEN; k++) begin
                r_geo[k] <= r_geo[k-1];
            end
        end
    end

    // origin difference, component products, dot sums
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_w0[k] = $signed({r_geo[0].oa[k][C_XW-1], r_geo[0].oa[k]})
                    - $signed({r_geo[0].ob[k][C_XW-1], r_geo[0].ob[k]});
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_p[0][k] = $signed({r_geo[1].da[k][C_XW-1], r_geo[1].da[k]})
                      * $signed({r_geo[1].da[k][C_XW-1], r_geo[1].da[k]});
            n_p[1][k] = $signed({r_geo[1].da[k][C_XW-1], r_geo[1].da[k]})
                      * $signed({r_geo[1].db[k][C_XW-1], r_geo[1].db[k]});
            n_p[2][k] = $signed({r_geo[1].db[k][C_XW-1], r_geo[1].db[k]})
                      * $signed({r_geo[1].db[k][C_XW-1], r_geo[1].db[k]});
            n_p[3][k] = $signed({r_geo[1].da[k][C_XW-1], r_geo[1].da[k]}) * r_w0[k];
            n_p[4][k] = $signed({r_geo[1].db[k][C_XW-1], r_geo[1].db[k]}) * r_w0[k];
        end
    end

    always_comb begin
        for (int j = 0; j < 5; j++) begin
            n_dot[j] = C_DOTW'(r_p[j][0] >>> 16) + C_DOTW'(r_p[j][1] >>> 16)
                     + C_DOTW'(r_p[j][2] >>> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w0  <= n_w0;
            r_p   <= n_p;
            r_dot <= n_dot;
        end
    end

    // a*c, b*b, b*e, c*d, a*e, b*d
    always_comb begin
        mx[0] = r_dot[0]; my[0] = r_dot[2];
        mx[1] = r_dot[1]; my[1] = r_dot[1];
        mx[2] = r_dot[1]; my[2] = r_dot[4];
        mx[3] = r_dot[2]; my[3] = r_dot[3];
        mx[4] = r_dot[0]; my[4] = r_dot[4];
        mx[5] = r_dot[1]; my[5] = r_dot[3];
    end

    for (genvar g = 0; g < 6; g++) begin : g_cross
        llcp_wmul #(.W(C_DOTW)) u_mul (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (mx[g]),
            .i_y   (my[g]),
            .o_p   (pr[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cc[0] <= r_dot[2];
            r_ee[0] <= r_dot[4];
            for (int k = 1; k < 3; k++) begin
                r_cc[k] <= r_cc[k-1];
                r_ee[k] <= r_ee[k-1];
            end
        end
    end

    always_comb begin
        n_den = C_DENW'(pr[0]) - C_DENW'(pr[1]);
        n_ns  = C_DENW'(pr[2]) - C_DENW'(pr[3]);
        n_nt  = C_DENW'(pr[4]) - C_DENW'(pr[5]);
    end

    // case selection and divider operands
    always_comb begin
        absden = r_den[C_DENW-1] ? (~r_den + C_DENW'(1)) : r_den;
        if (r_cc[2] == '0) begin
            n_st8 = ST_ZERO_DIR;
        end else if (absden <= C_DENW'(r_thr)) begin
            n_st8 = ST_PARALLEL;
        end else begin
            n_st8 = ST_GENERAL;
        end
        n_nums = C_NUMW'(r_ns) <<< 16;
        n_dens = r_den;
        if (n_st8 == ST_PARALLEL) begin
            n_numt = C_NUMW'(r_ee[2]) <<< 16;
            n_dent = C_DENW'(r_cc[2]);
        end else begin
            n_numt = C_NUMW'(r_nt) <<< 16;
            n_dent = r_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_den  <= n_den;
            r_ns   <= n_ns;
            r_nt   <= n_nt;
            r_st8  <= n_st8;
            r_nums <= n_nums;
            r_dens <= n_dens;
            r_numt <= n_numt;
            r_dent <= n_dent;
        end
    end

    llcp_div #(.NW(C_NUMW), .DW(C_DENW), .QW(C_QW)) u_div_s (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_nums),
        .i_den (r_dens),
        .o_quo (s_quo)
    );

    llcp_div #(.NW(C_NUMW), .DW(C_DENW), .QW(C_QW)) u_div_t (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_numt),
        .i_den (r_dent),
        .o_quo (t_quo)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0] <= r_st8;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_st[k] <= r_st[k-1];
            end
        end
    end

    // closest points
    always_comb begin
        n_s = (r_st[DIV_LAT-1] == ST_GENERAL) ? s_quo : '0;
        n_t = (r_st[DIV_LAT-1] == ST_ZERO_DIR) ? '0 : t_quo;
        for (int k = 0; k < 3; k++) begin
            n_ma[k] = n_s * $signed(r_geo[GEO_LEN-2].da[k]);
            n_mb[k] = n_t * $signed(r_geo[GEO_LEN-2].db[k]);
        end
        n_o44         = '0;
        n_o44.param_s = n_s;
        n_o44.param_t = n_t;
        n_o44.status  = r_st[DIV_LAT-1];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pa[k] = PTW'($signed(r_geo[GEO_LEN-1].oa[k])) + PTW'(r_ma[k] >>> 16);
            n_pb[k] = PTW'($signed(r_geo[GEO_LEN-1].ob[k])) + PTW'(r_mb[k] >>> 16);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_df[k] = C_DIFW'(r_pa[k]) - C_DIFW'(r_pb[k]);
        end
        n_o46          = r_o45;
        n_o46.near_a_x = f_sat32(r_pa[0]);
        n_o46.near_a_y = f_sat32(r_pa[1]);
        n_o46.near_a_z = f_sat32(r_pa[2]);
        n_o46.near_b_x = f_sat32(r_pb[0]);
        n_o46.near_b_y = f_sat32(r_pb[1]);
        n_o46.near_b_z = f_sat32(r_pb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_o44 <= n_o44;
            r_pa  <= n_pa;
            r_pb  <= n_pb;
            r_o45 <= r_o44;
            r_df  <= n_df;
            r_o46 <= n_o46;
            r_o47 <= r_o46;
            r_o48 <= r_o47;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_sq
        llcp_wmul #(.W(C_DIFW)) u_mul (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (r_df[g]),
            .i_y   (r_df[g]),
            .o_p   (sq[g])
        );
    end

    always_comb begin
        n_sum = SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);
        n_out = r_o48;
        if (n_sum[SUMW-1:C_DISTW+16] != '0) begin
            n_out.dist_sq = '1;
        end else begin
            n_out.dist_sq = n_sum[C_DISTW+15:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    a_zero_dir : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_ZERO_DIR) |->
            (o_data.param_s == '0 && o_data.param_t == '0))
        else $error("zero direction result with nonzero parameter");

    a_parallel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_PARALLEL) |-> (o_data.param_s == '0))
        else $error("parallel result with nonzero s");

    a_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while pipeline is held");

endmodule
`default_nettype wire
